[hw/rtl/correction_table_interpolator_assert.svh]
// Assertion helpers shared by the RTL of the correction table interpolator.
`ifndef CORRECTION_TABLE_INTERPOLATOR_ASSERT_SVH
`define CORRECTION_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cti_pkg.sv]
package cti_pkg;

	localparam int FREQ_W   = 40;
	localparam int CORR_W   = 16;
	localparam int SEG_W    = 6;
	localparam int INDEX_W  = 6;
	localparam int PCOUNT_W = 7;
	localparam int DELTA_W  = CORR_W + 1;
	localparam int SUM_W    = CORR_W + 2;
	localparam int HALF_W   = FREQ_W / 2;
	localparam int HIGH_W   = FREQ_W - HALF_W;
	localparam int PROD_W   = CORR_W + FREQ_W + 1;
	localparam int APB_DW   = 32;
	localparam int ADDR_W   = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [PCOUNT_W-1:0] POINT_COUNT_RESET = 7'd1;

	localparam logic signed [SUM_W-1:0] CORR_SAT_HI = 18'sd32767;
	localparam logic signed [SUM_W-1:0] CORR_SAT_LO = -18'sd32767;

	typedef struct packed {
		logic                     req_type;
		logic [INDEX_W-1:0]       entry_index;
		logic [FREQ_W-1:0]        point_frequency;
		logic signed [CORR_W-1:0] point_correction;
		logic [FREQ_W-1:0]        query_frequency;
	} request_t;

	typedef struct packed {
		logic signed [CORR_W-1:0] correction;
		logic [SEG_W-1:0]         segment_used;
	} result_t;

	typedef struct packed {
		logic [FREQ_W-1:0]        freq;
		logic signed [CORR_W-1:0] corr;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [FREQ_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_CURS,
		ST_WALK,
		ST_PREP,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_GO,
		ST_DIV_WAIT
	} cti_state_t;

endpackage

[hw/rtl/cti_ram.sv]
module cti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/cti_div.sv]
module cti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cti_pkg::div_req_t div_req,
	output cti_pkg::div_rsp_t div_rsp
);

	import cti_pkg::*;

	`include "correction_table_interpolator_assert.svh"

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] quo_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dvs_q;

	logic [FREQ_W:0] trial;
	logic [FREQ_W:0] diff;
	logic            fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			quo_q <= div_req.dividend;
			rem_q <= '0;
			dvs_q <= div_req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign div_rsp.done     = done_q;
	assign div_rsp.quotient = quo_q;

	`CTI_ASSERT_IMPL(a_no_restart_in_flight, clk, arst_n, div_req.start, !busy_q,
		"divider restarted while busy")

endmodule

[hw/rtl/correction_table_interpolator.sv]
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+-----------------------------------
// request   | start, busy (taken: start&&!busy) | cti_pkg::request_t request
// result    | result_valid, one-cycle strobe   | cti_pkg::result_t result
// config    | APB write, pready tied high      | point_count at byte address 0
//
// A load request is written to the table as it is taken and leaves busy low.
// Queries at or below the first point or at or above the last point return without interpolating.
// An interpolated query walks over k segments: the walk costs one table read per segment, and
// the restoring divider produces one quotient bit per cycle.
// Reset leaves point_count at 1 and the cursor at segment 0; the table is not cleared.
// The result receiver cannot stall; each result is shown for exactly one cycle.
module correction_table_interpolator #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                start,
	output logic                                busy,
	input  cti_pkg::request_t                   request,
	// result channel
	output logic                                result_valid,
	output cti_pkg::result_t                    result,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cti_pkg::ADDR_W-1:0]          paddr,
	input  logic [cti_pkg::APB_DW-1:0]          pwdata,
	output logic [cti_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);

	import cti_pkg::*;

	`include "correction_table_interpolator_assert.svh"

	localparam int AW      = $clog2(MAX_POINTS);
	localparam int ENTRY_W = $bits(entry_t);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [PCOUNT_W-1:0]  point_count_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RESET;
		end else if (cfg_write && reg_idx == REG_POINT_COUNT) begin
			point_count_q <= pwdata[PCOUNT_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_POINT_COUNT) ? APB_DW'(point_count_q) : '0;

	// last point in use: zero count acts as one point, large counts saturate
	logic [AW-1:0] last_pt;

	always_comb begin
		if (point_count_q == '0) begin
			last_pt = '0;
		end else if (32'(point_count_q) > MAX_POINTS) begin
			last_pt = AW'(MAX_POINTS - 1);
		end else begin
			last_pt = AW'(point_count_q - PCOUNT_W'(1));
		end
	end

	// ------------------------------------------------------------------
	// Table memory: one entry holds a point's frequency and correction.
	// Loads and queries never overlap (a query holds busy until its result),
	// so a read never races a write to the same entry.
	// ------------------------------------------------------------------
	logic               accept;
	logic               load_ok;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	entry_t             ram_wentry;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;

	assign accept     = start && !busy;
	assign load_ok    = 32'(request.entry_index) < MAX_POINTS;
	assign ram_we     = accept && request.req_type == REQ_LOAD && load_ok;
	assign ram_waddr  = AW'(request.entry_index);
	assign ram_wentry = '{freq: request.point_frequency, corr: request.point_correction};
	assign rd_entry   = ram_rdata;

	cti_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Query datapath registers
	// ------------------------------------------------------------------
	cti_state_t state_q;
	cti_state_t state_d;

	logic [FREQ_W-1:0] f_q;
	entry_t            e0_q;
	entry_t            lo_q;
	entry_t            hi_q;
	logic [AW-1:0]     seg_q;
	logic [AW-1:0]     cursor_q;
	logic [FREQ_W-1:0] span_q;
	logic [FREQ_W-1:0] off_q;
	logic [CORR_W-1:0] mag_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// compares against the entry read in the previous cycle
	logic q_le_rd;
	logic q_ge_rd;
	logic q_lt_rd;
	logic q_gt_rd;
	logic first_hit;
	logic cur_reset;
	logic zero_span;

	assign q_le_rd   = f_q <= rd_entry.freq;
	assign q_ge_rd   = f_q >= rd_entry.freq;
	assign q_lt_rd   = f_q < rd_entry.freq;
	assign q_gt_rd   = f_q > rd_entry.freq;
	assign first_hit = q_le_rd || last_pt == '0;
	assign cur_reset = cursor_q >= last_pt || q_lt_rd;
	assign zero_span = hi_q.freq <= lo_q.freq || f_q < lo_q.freq;

	// segment span, offset and correction step
	logic [FREQ_W-1:0]        span_w;
	logic [FREQ_W-1:0]        off_w;
	logic signed [DELTA_W-1:0] delta_w;
	logic signed [DELTA_W-1:0] mag_w;

	assign span_w  = hi_q.freq - lo_q.freq;
	assign off_w   = f_q - lo_q.freq;
	assign delta_w = DELTA_W'(hi_q.corr) - DELTA_W'(lo_q.corr);
	assign mag_w   = delta_w[DELTA_W-1] ? -delta_w : delta_w;

	// one shared multiplier, low half of the offset first, then the high half
	logic [HIGH_W-1:0]        pp_op;
	logic [CORR_W+HIGH_W-1:0] pp;

	assign pp_op = (state_q == ST_MUL_LO) ? HIGH_W'(off_q[HALF_W-1:0])
	                                      : off_q[FREQ_W-1:HALF_W];
	assign pp    = (CORR_W + HIGH_W)'(mag_q) * (CORR_W + HIGH_W)'(pp_op);

	// apply the rounded quotient and saturate
	logic signed [SUM_W-1:0] corr_ext;
	logic signed [SUM_W-1:0] quo_ext;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [CORR_W-1:0] interp_corr;

	assign corr_ext = SUM_W'(lo_q.corr);
	assign quo_ext  = signed'(SUM_W'(div_rsp.quotient[DELTA_W-1:0]));
	assign sum_w    = neg_q ? corr_ext - quo_ext : corr_ext + quo_ext;

	always_comb begin
		if (sum_w > CORR_SAT_HI) begin
			interp_corr = CORR_SAT_HI[CORR_W-1:0];
		end else if (sum_w < CORR_SAT_LO) begin
			interp_corr = CORR_SAT_LO[CORR_W-1:0];
		end else begin
			interp_corr = sum_w[CORR_W-1:0];
		end
	end

	cti_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && request.req_type == REQ_QUERY) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST:    state_d = first_hit ? ST_IDLE : ST_LAST;
			ST_LAST:     state_d = q_ge_rd ? ST_IDLE : ST_CURS;
			ST_CURS:     state_d = ST_WALK;
			ST_WALK:     state_d = q_gt_rd ? ST_WALK : ST_PREP;
			ST_PREP:     state_d = zero_span ? ST_IDLE : ST_MUL_LO;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: state_d = div_rsp.done ? ST_IDLE : ST_DIV_WAIT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs (read address, divider start, result)
	// ------------------------------------------------------------------
	logic                     emit;
	logic signed [CORR_W-1:0] emit_corr;
	logic [AW-1:0]            emit_seg;

	always_comb begin
		ram_raddr        = '0;
		emit             = 1'b0;
		emit_corr        = rd_entry.corr;
		emit_seg         = seg_q;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = span_q;
		unique case (state_q)
			ST_IDLE: begin
				// fetch the first point as the request arrives
				ram_raddr = '0;
			end
			ST_FIRST: begin
				ram_raddr = last_pt;
				emit      = first_hit;
				emit_seg  = '0;
			end
			ST_LAST: begin
				ram_raddr = cursor_q;
				emit      = q_ge_rd;
				emit_seg  = last_pt;
			end
			ST_CURS: begin
				// drop a stale cursor and restart at the first segment
				ram_raddr = cur_reset ? AW'(1) : cursor_q + AW'(1);
			end
			ST_WALK: begin
				ram_raddr = seg_q + AW'(2);
			end
			ST_PREP: begin
				emit      = zero_span;
				emit_corr = lo_q.corr;
			end
			ST_MUL_LO, ST_MUL_HI: begin
				ram_raddr = '0;
			end
			ST_DIV_GO: begin
				div_req.start = 1'b1;
			end
			ST_DIV_WAIT: begin
				emit      = div_rsp.done;
				emit_corr = interp_corr;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	logic    result_valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cursor_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit;
			// restart the cursor on every load, track it on every query
			if (accept && request.req_type == REQ_LOAD) begin
				cursor_q <= '0;
			end else if (state_q == ST_FIRST && first_hit) begin
				cursor_q <= '0;
			end else if (state_q == ST_LAST && q_ge_rd) begin
				cursor_q <= last_pt;
			end else if (state_q == ST_WALK && !q_gt_rd) begin
				cursor_q <= seg_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.correction   <= emit_corr;
			result_q.segment_used <= SEG_W'(emit_seg);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					f_q <= request.query_frequency;
				end
			end
			ST_FIRST: begin
				e0_q <= rd_entry;
			end
			ST_CURS: begin
				if (cur_reset) begin
					lo_q  <= e0_q;
					seg_q <= '0;
				end else begin
					lo_q  <= rd_entry;
					seg_q <= cursor_q;
				end
			end
			ST_WALK: begin
				// advance while the query lies beyond the segment end
				if (q_gt_rd) begin
					lo_q  <= rd_entry;
					seg_q <= seg_q + AW'(1);
				end else begin
					hi_q <= rd_entry;
				end
			end
			ST_PREP: begin
				span_q <= span_w;
				off_q  <= off_w;
				mag_q  <= mag_w[CORR_W-1:0];
				neg_q  <= delta_w[DELTA_W-1];
				// start the numerator at the rounding bias of half a span
				prod_q <= PROD_W'(span_w >> 1);
			end
			ST_MUL_LO: begin
				prod_q <= prod_q + PROD_W'(pp);
			end
			ST_MUL_HI: begin
				prod_q <= prod_q + (PROD_W'(pp) << HALF_W);
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`CTI_ASSERT_NEXT(a_query_reads_first, clk, arst_n,
		accept && request.req_type == REQ_QUERY, state_q == ST_FIRST,
		"accepted query did not start the lookup")

	`CTI_ASSERT_IMPL(a_walk_below_last, clk, arst_n,
		state_q == ST_WALK, seg_q < last_pt,
		"segment walk ran past the last segment")

	`CTI_ASSERT_NEXT(a_div_done_gives_result, clk, arst_n,
		state_q == ST_DIV_WAIT && div_rsp.done, result_valid_q,
		"quotient ready but no result issued")

	`CTI_ASSERT_IMPL(a_result_follows_work, clk, arst_n,
		result_valid_q, $past(state_q) != ST_IDLE,
		"result issued without a query in flight")

endmodule
